@@ rtl/core/gfm_pkg.sv @@
// Shared types and constants for the GB2312 font ROM address mapper.
package gfm_pkg;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_WIDE   = 2'd1,
    KIND_NARROW = 2'd2,
    KIND_SMALL  = 2'd3
  } glyph_kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
    logic [7:0] start_column;
    logic [7:0] start_page;
  } text_item_t;

  typedef struct packed {
    logic [17:0] font_address;
    glyph_kind_t glyph_kind;
    logic [7:0]  glyph_page;
    logic [7:0]  glyph_column;
    logic        string_end;
  } glyph_item_t;

  localparam logic [7:0] HANZI_LEAD_LO = 8'hB0;
  localparam logic [7:0] HANZI_LEAD_HI = 8'hF7;
  localparam logic [7:0] SYMBOL_LO     = 8'hA1;
  localparam logic [7:0] SYMBOL_LEAD_HI = 8'hA3;
  localparam logic [7:0] ASCII_LO      = 8'h20;
  localparam logic [7:0] ASCII_HI      = 8'h7E;
  localparam logic [6:0] ROW_SIZE      = 7'd94;
  localparam logic [12:0] HANZI_BASE   = 13'd846;
  localparam logic [17:0] NARROW_BASE  = 18'h3CF80;
  localparam logic [17:0] SMALL_BASE   = 18'h3BFC0;
  localparam logic [7:0] WIDE_STEP     = 8'd16;
  localparam logic [7:0] NARROW_STEP   = 8'd8;
  localparam logic [7:0] SMALL_STEP    = 8'd6;

endpackage

@@ rtl/core/gfm_ifs.sv @@
// Valid/ready channel interfaces for text input words and glyph result words.
interface gfm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       string_start;
  logic [7:0] start_column;
  logic [7:0] start_page;

  modport source (output valid, output text_byte, output string_start,
                  output start_column, output start_page, input ready);
  modport sink (input valid, input text_byte, input string_start,
                input start_column, input start_page, output ready);
endinterface

interface gfm_glyph_if;
  logic        valid;
  logic        ready;
  logic [17:0] font_address;
  logic [1:0]  glyph_kind;
  logic [7:0]  glyph_page;
  logic [7:0]  glyph_column;
  logic        string_end;

  modport source (output valid, output font_address, output glyph_kind,
                  output glyph_page, output glyph_column, output string_end,
                  input ready);
  modport sink (input valid, input font_address, input glyph_kind,
                input glyph_page, input glyph_column, input string_end,
                output ready);
endinterface

@@ rtl/core/gfm_in_stage.sv @@
// Input register that holds one accepted text word until the mapper takes it.
module gfm_in_stage (
  input  logic               clk,
  input  logic               rst,
  gfm_text_if.sink           text,
  input  logic               advance,
  output logic               item_valid,
  output gfm_pkg::text_item_t item
);
  import gfm_pkg::*;

  assign text.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (text.ready) begin
      item_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      item.text_byte    <= text.text_byte;
      item.string_start <= text.string_start;
      item.start_column <= text.start_column;
      item.start_page   <= text.start_page;
    end
  end

endmodule

@@ rtl/core/gfm_map.sv @@
// Decode of one text word against the lead, page and column state.
module gfm_map (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 font_mode,
  input  gfm_pkg::text_item_t  item,
  output logic                 res_valid,
  output gfm_pkg::glyph_item_t res
);
  import gfm_pkg::*;

  logic        lead_pending;
  logic [7:0]  lead_byte;
  logic [7:0]  current_column;
  logic [7:0]  current_page;
  logic        lead_pending_next;
  logic [7:0]  lead_byte_next;
  logic [7:0]  current_column_next;

  logic [7:0]  b;
  logic [7:0]  col;
  logic [7:0]  page;
  logic        pend;
  logic        is_ascii;
  logic        is_lead;
  logic        lead_hanzi;
  logic [6:0]  lead_off;
  logic [12:0] row_base;
  logic [12:0] glyph_index;
  logic [6:0]  ascii_off;
  logic [17:0] wide_addr;
  logic [17:0] narrow_addr;
  logic [17:0] small_addr;

  assign b    = item.text_byte;
  assign col  = item.string_start ? item.start_column : current_column;
  assign page = item.string_start ? item.start_page : current_page;
  assign pend = item.string_start ? 1'b0 : lead_pending;

  assign is_ascii = (b >= ASCII_LO) && (b <= ASCII_HI);
  assign is_lead  = ((b >= HANZI_LEAD_LO) && (b <= HANZI_LEAD_HI)) ||
                    ((b >= SYMBOL_LO) && (b <= SYMBOL_LEAD_HI));

  assign lead_hanzi  = lead_byte >= HANZI_LEAD_LO;
  assign lead_off    = lead_hanzi ? 7'(lead_byte - HANZI_LEAD_LO)
                                  : 7'(lead_byte - SYMBOL_LO);
  assign row_base    = lead_hanzi ? HANZI_BASE : 13'd0;
  assign glyph_index = 13'(lead_off) * 13'(ROW_SIZE) + 13'(b - SYMBOL_LO) + row_base;
  assign wide_addr   = {glyph_index, 5'b0};

  assign ascii_off   = 7'(b - ASCII_LO);
  assign narrow_addr = NARROW_BASE + {7'b0, ascii_off, 4'b0};
  assign small_addr  = SMALL_BASE + {8'b0, ascii_off, 3'b0};

  always_comb begin
    res_valid           = 1'b0;
    res.font_address    = 18'd0;
    res.glyph_kind      = KIND_NONE;
    res.glyph_page      = page;
    res.glyph_column    = col;
    res.string_end      = 1'b0;
    lead_pending_next   = pend;
    lead_byte_next      = lead_byte;
    current_column_next = col;
    priority if (b == 8'd0) begin
      lead_pending_next = 1'b0;
      res_valid         = 1'b1;
      res.string_end    = 1'b1;
    end else if (font_mode) begin
      lead_pending_next = 1'b0;
      if (is_ascii) begin
        res_valid           = 1'b1;
        res.font_address    = small_addr;
        res.glyph_kind      = KIND_SMALL;
        current_column_next = col + SMALL_STEP;
      end
    end else if (pend && (b >= SYMBOL_LO)) begin
      lead_pending_next   = 1'b0;
      res_valid           = 1'b1;
      res.font_address    = wide_addr;
      res.glyph_kind      = KIND_WIDE;
      current_column_next = col + WIDE_STEP;
    end else if (is_lead) begin
      lead_pending_next = 1'b1;
      lead_byte_next    = b;
    end else begin
      lead_pending_next = 1'b0;
      if (is_ascii) begin
        res_valid           = 1'b1;
        res.font_address    = narrow_addr;
        res.glyph_kind      = KIND_NARROW;
        current_column_next = col + NARROW_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending   <= 1'b0;
      lead_byte      <= 8'd0;
      current_column <= 8'd0;
      current_page   <= 8'd0;
    end else if (advance) begin
      lead_pending   <= lead_pending_next;
      lead_byte      <= lead_byte_next;
      current_column <= current_column_next;
      current_page   <= page;
    end
  end

endmodule

@@ rtl/core/gfm_out_stage.sv @@
// Result register that drives the glyph channel.
module gfm_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  gfm_pkg::glyph_item_t res,
  output logic                 free,
  gfm_glyph_if.source          glyph
);
  import gfm_pkg::*;

  glyph_item_t held;

  assign free = !glyph.valid || glyph.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph.valid <= 1'b0;
    end else if (free) begin
      glyph.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign glyph.font_address = held.font_address;
  assign glyph.glyph_kind   = held.glyph_kind;
  assign glyph.glyph_page   = held.glyph_page;
  assign glyph.glyph_column = held.glyph_column;
  assign glyph.string_end   = held.string_end;

endmodule

@@ rtl/core/gb2312_font_rom_address_mapper.sv @@
// Top level of the GB2312 and ASCII font ROM address mapper.
// Takes one text word per cycle and answers each completed glyph with its font ROM
// address, kind, page and column; lead bytes and skipped bytes give no word, and the
// zero byte gives an end-of-string word. Each result passes through the input register
// and the result register, and a full sustained rate of one word per cycle is kept
// as long as the glyph channel takes its results.
module gb2312_font_rom_address_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        font_mode_we,
  input  logic        font_mode_wdata,
  gfm_text_if.sink    text,
  gfm_glyph_if.source glyph
);
  import gfm_pkg::*;

  logic        font_mode;
  logic        item_valid;
  text_item_t  item;
  logic        res_valid;
  glyph_item_t res;
  logic        out_free;
  logic        advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_mode <= 1'b0;
    end else if (font_mode_we) begin
      font_mode <= font_mode_wdata;
    end
  end

  assign advance = item_valid && out_free;

  gfm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  gfm_map u_map (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .font_mode (font_mode),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  gfm_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (advance && res_valid),
    .res   (res),
    .free  (out_free),
    .glyph (glyph)
  );

`ifndef SYNTHESIS
  a_end_word_is_blank: assert property (@(posedge clk) disable iff (rst)
    glyph.valid && glyph.string_end |->
      glyph.glyph_kind == KIND_NONE && glyph.font_address == 18'd0)
    else $error("end word carries a glyph");

  a_glyph_not_end: assert property (@(posedge clk) disable iff (rst)
    glyph.valid && glyph.glyph_kind != KIND_NONE |-> !glyph.string_end)
    else $error("glyph word flagged as end");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid)
    else $error("pending input word lost");
`endif

endmodule
